// ----- src/arw_pkg.sv -----
// ----------------------------------------------------------------------------
// arw_pkg: shared types and codes for the anti-replay window
// Request command codes and the request record passed between the stages.
// ----------------------------------------------------------------------------
package arw_pkg;

    // Request command codes
    localparam logic CMD_CHECK  = 1'b0;
    localparam logic CMD_ACCEPT = 1'b1;

    localparam int SEQ_W  = 64;
    localparam int DIST_W = 32;

    typedef struct packed {
        logic             cmd;
        logic [SEQ_W-1:0] seq_num;
    } arw_item_t;

    // Request held in the input register, with its valid flag
    typedef struct packed {
        logic      valid;
        arw_item_t item;
    } arw_stage_t;

endpackage

// ----- src/arw_pkt_if.sv -----
// ----------------------------------------------------------------------------
// arw_pkt_if: packet request channel
// Carries one check or accept request per handshake.
// ----------------------------------------------------------------------------
interface arw_pkt_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [63:0] seq_num;

    modport source (output valid, output cmd, output seq_num, input ready);
    modport sink   (input valid, input cmd, input seq_num, output ready);
endinterface

// ----- src/arw_verdict_if.sv -----
// ----------------------------------------------------------------------------
// arw_verdict_if: verdict channel
// Carries the fresh flag answered for each request.
// ----------------------------------------------------------------------------
interface arw_verdict_if;
    logic valid;
    logic ready;
    logic fresh;

    modport source (output valid, output fresh, input ready);
    modport sink   (input valid, input fresh, output ready);
endinterface

// ----- src/anti_replay_window.sv -----
// ----------------------------------------------------------------------------
// anti_replay_window: sliding-window anti-replay filter
// Answers whether a packet sequence number is fresh and records accepted ones.
// ----------------------------------------------------------------------------
// Usage:
//   pkt carries requests: cmd selects check (answer only) or accept (record
//   the number); seq_num is the 64-bit sequence number. Distances between
//   numbers are wrapped 32-bit signed differences of their low halves.
//   verdict returns one fresh flag per request, in request order; an accept
//   always answers fresh = 1.
//   A request is held in the input register and then moves into the verdict
//   register, where its verdict turns valid; a stalled verdict holds it back.
//   Throughput: one request per cycle while verdict is not stalled. The
//   window update (bitmap shift or mark and the highest-number register) is
//   registered with the verdict, so a check sees every accept taken before it.
//   Reset clears the highest number and the whole bitmap at once; requests
//   are taken from the first cycle after reset.
//   When verdict is stalled, the pending verdict holds, one more request
//   waits in the input register, and pkt.ready then drops until the
//   verdict is taken.
// ----------------------------------------------------------------------------
module anti_replay_window
#(
    parameter int WINDOW_BITS = 1024
)
(
    input  logic          clk,
    input  logic          rst_n,
    arw_pkt_if.sink       pkt,
    arw_verdict_if.source verdict
);
    import arw_pkg::*;

    arw_stage_t stage;
    logic       advance;

    // Capture requests
    arw_in_reg u_in_reg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .pkt     (pkt),
        .advance (advance),
        .stage   (stage)
    );

    // Update the window and produce verdicts
    arw_window #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_window
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .stage   (stage),
        .advance (advance),
        .verdict (verdict)
    );

endmodule

// ----- src/arw_in_reg.sv -----
// ----------------------------------------------------------------------------
// arw_in_reg: input register
// Captures one request and holds it until the window stage takes it.
// ----------------------------------------------------------------------------
module arw_in_reg
(
    input  logic                clk,
    input  logic                rst_n,
    arw_pkt_if.sink             pkt,
    input  logic                advance,
    output arw_pkg::arw_stage_t stage
);
    import arw_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    arw_item_t item_reg;
    logic      take;

    // Accept when empty or when the held request moves on this cycle
    assign pkt.ready = !valid_reg || advance;
    assign take      = pkt.valid && pkt.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on accept
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.cmd     <= pkt.cmd;
            item_reg.seq_num <= pkt.seq_num;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

// ----- src/arw_window.sv -----
// ----------------------------------------------------------------------------
// arw_window: window state, verdict logic and verdict register
// Keeps the highest accepted number and the seen bitmap, answers checks and
// records accepts, one request per cycle while the verdict is not stalled.
// ----------------------------------------------------------------------------
module arw_window
#(
    parameter int WINDOW_BITS = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  arw_pkg::arw_stage_t stage,
    output logic                advance,
    arw_verdict_if.source       verdict
);
    import arw_pkg::*;

    localparam int                IDX_W     = $clog2(WINDOW_BITS);
    localparam logic [DIST_W-1:0] WIN_LIMIT = DIST_W'(WINDOW_BITS);

    logic [SEQ_W-1:0]       highest_reg;
    logic [SEQ_W-1:0]       highest_next;
    logic [WINDOW_BITS-1:0] bitmap_reg;
    logic [WINDOW_BITS-1:0] bitmap_next;
    logic [WINDOW_BITS-1:0] shifted;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   fresh_reg;
    logic                   fresh_next;
    logic [DIST_W-1:0]      gap;
    logic [DIST_W-1:0]      lag;
    logic                   ahead;
    logic                   check_fresh;
    logic                   process;

    // Move on when the verdict register is free or being drained
    assign advance = !out_valid_reg || verdict.ready;
    assign process = stage.valid && advance;

    // Wrapped 32-bit distances; lag is also the negated gap
    assign gap   = stage.item.seq_num[DIST_W-1:0] - highest_reg[DIST_W-1:0];
    assign lag   = highest_reg[DIST_W-1:0] - stage.item.seq_num[DIST_W-1:0];
    assign ahead = (gap != '0) && !gap[DIST_W-1];

    // Check: ahead is fresh, inside the window fresh if unmarked, too old is not
    always_comb
    begin
        if (lag[DIST_W-1])
        begin
            check_fresh = 1'b1;
        end
        else if (lag < WIN_LIMIT)
        begin
            check_fresh = !bitmap_reg[lag[IDX_W-1:0]];
        end
        else
        begin
            check_fresh = 1'b0;
        end
    end

    assign shifted = bitmap_reg << gap[IDX_W-1:0];

    // Accept: slide or clear the window when ahead, else mark the bit behind
    always_comb
    begin
        highest_next = highest_reg;
        bitmap_next  = bitmap_reg;
        if (process && stage.item.cmd == CMD_ACCEPT)
        begin
            if (ahead)
            begin
                bitmap_next    = (gap >= WIN_LIMIT) ? '0 : shifted;
                bitmap_next[0] = 1'b1;
                highest_next   = stage.item.seq_num;
            end
            else if (lag < WIN_LIMIT)
            begin
                bitmap_next[lag[IDX_W-1:0]] = 1'b1;
            end
        end
    end

    // Verdict register control
    always_comb
    begin
        out_valid_next = out_valid_reg;
        fresh_next     = fresh_reg;
        if (process)
        begin
            out_valid_next = 1'b1;
            fresh_next     = (stage.item.cmd == CMD_CHECK) ? check_fresh : 1'b1;
        end
        else if (verdict.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            highest_reg   <= '0;
            bitmap_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            highest_reg   <= highest_next;
            bitmap_reg    <= bitmap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the verdict payload
    always_ff @(posedge clk)
    begin
        fresh_reg <= fresh_next;
    end

    assign verdict.valid = out_valid_reg;
    assign verdict.fresh = fresh_reg;

endmodule

// ----- src/arw_checker.sv -----
// ----------------------------------------------------------------------------
// arw_checker: port-level checks for the anti-replay window
// Watches the request and verdict channels and flags ordering slips.
// ----------------------------------------------------------------------------
module arw_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        pkt_valid,
    input logic        pkt_ready,
    input logic        pkt_cmd,
    input logic        verdict_valid,
    input logic        verdict_ready,
    input logic        verdict_fresh
);
    import arw_pkg::*;

    // Hold a stalled verdict
    a_verdict_hold: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid && !verdict_ready |=> verdict_valid)
        else $error("verdict dropped while stalled");

    a_fresh_stable: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid && !verdict_ready |=> $stable(verdict_fresh))
        else $error("verdict payload changed while stalled");

    // A taken request yields its verdict once verdict.ready lets it leave the input register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (pkt_valid && pkt_ready) ##1 verdict_ready |=> verdict_valid)
        else $error("verdict missing two cycles after request");

    // An accept always answers fresh
    a_accept_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        (pkt_valid && pkt_ready && pkt_cmd == CMD_ACCEPT) ##1 verdict_ready
        |=> verdict_valid && verdict_fresh)
        else $error("accept answered not fresh");

endmodule

bind anti_replay_window arw_checker u_arw_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .pkt_valid     (pkt.valid),
    .pkt_ready     (pkt.ready),
    .pkt_cmd       (pkt.cmd),
    .verdict_valid (verdict.valid),
    .verdict_ready (verdict.ready),
    .verdict_fresh (verdict.fresh)
);

// ----- tb/anti_replay_window_tb.sv -----
// ----------------------------------------------------------------------------
// anti_replay_window_tb: self-checking bench for the anti-replay window
// Streams check and accept requests with random gaps and verdict stalls,
// keeps its own copy of the highest number and the seen bitmap, and compares
// every verdict against the predicted fresh flag in request order.
// ----------------------------------------------------------------------------
module anti_replay_window_tb;
    import arw_pkg::*;

    localparam int WIN        = 1024;
    localparam int IDLE_LIMIT = 2000;
    localparam int RAND_REQS  = 600;

    typedef struct {
        logic        cmd;
        logic [63:0] seq;
        int unsigned gap;
        bit          drain;
    } pkt_req_t;

    logic clk;
    logic rst_n;

    arw_pkt_if     pkt_ch();
    arw_verdict_if verdict_ch();

    anti_replay_window #(
        .WINDOW_BITS(WIN)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pkt     (pkt_ch.sink),
        .verdict (verdict_ch.source)
    );

    // Predicted window state
    logic [63:0]    win_high;
    logic [WIN-1:0] win_map;

    // Pending requests and predicted verdicts
    pkt_req_t    pend_q[$];
    logic        verdict_due[$];
    pkt_req_t    cur_req;

    logic [63:0] gen_high;
    bit          tx_calm;
    bit          rx_calm;
    bit          drv_busy;
    bit          req_taken;
    bit          verdict_took;
    int unsigned gap_cnt;
    int unsigned stall_cnt;
    int unsigned idle_cycles;
    int unsigned errors;
    logic        want_fresh;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Apply one request to the predicted window and return its fresh flag
    function automatic logic replay_verdict(input logic cmd, input logic [63:0] seq);
        logic signed [31:0] d;
        longint             back;
        logic               fresh;
        fresh = 1'b1;
        if (cmd == CMD_CHECK)
        begin
            d = win_high[31:0] - seq[31:0];
            if (d >= 0)
            begin
                if (d >= WIN)
                    fresh = 1'b0;
                else if (win_map[d])
                    fresh = 1'b0;
            end
        end
        else
        begin
            d = seq[31:0] - win_high[31:0];
            if (d > 0)
            begin
                // advance: slide the bitmap or clear it on a long jump
                if (d >= WIN)
                    win_map = '0;
                else
                    win_map = win_map << d;
                win_map[0] = 1'b1;
                win_high   = seq;
            end
            else
            begin
                // mark a number at or behind the highest, drop it if too old
                back = -longint'(d);
                if (back < WIN)
                    win_map[back] = 1'b1;
            end
        end
        return fresh;
    endfunction

    // Queue a request and track the highest number the stimulus has pushed
    task automatic queue_req(input logic cmd, input logic [63:0] seq, input bit drain);
        pkt_req_t           r;
        logic signed [31:0] ahead;
        if ($urandom_range(0, 39) == 0)
            tx_calm = !tx_calm;
        r.cmd   = cmd;
        r.seq   = seq;
        r.gap   = tx_calm ? 0 : $urandom_range(0, 14);
        r.drain = drain;
        pend_q.push_back(r);
        ahead = seq[31:0] - gen_high[31:0];
        if (cmd == CMD_ACCEPT && ahead > 0)
            gen_high = seq;
    endtask

    // Driver: present pending requests at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pkt_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_taken)
            begin
                req_taken = 1'b0;
                drv_busy  = 1'b0;
            end
            if (!drv_busy && pend_q.size() != 0)
            begin
                if (gap_cnt < pend_q[0].gap)
                    gap_cnt++;
                else if (!(pend_q[0].drain && verdict_due.size() != 0))
                begin
                    cur_req = pend_q.pop_front();
                    pkt_ch.cmd     <= cur_req.cmd;
                    pkt_ch.seq_num <= cur_req.seq;
                    drv_busy = 1'b1;
                    gap_cnt  = 0;
                end
            end
            pkt_ch.valid <= drv_busy;
        end
    end

    // Verdict back-pressure: drop ready for a random stall after each take
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            verdict_ch.ready <= 1'b0;
        end
        else
        begin
            if (verdict_took)
            begin
                verdict_took = 1'b0;
                if ($urandom_range(0, 39) == 0)
                    rx_calm = !rx_calm;
                stall_cnt = rx_calm ? 0 : $urandom_range(0, 14);
            end
            else if (stall_cnt != 0)
            begin
                stall_cnt--;
            end
            verdict_ch.ready <= (stall_cnt == 0);
        end
    end

    // Monitor: check verdicts, predict accepted requests, guard against hangs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (verdict_ch.valid && verdict_ch.ready)
            begin
                verdict_took = 1'b1;
                if (verdict_due.size() == 0)
                begin
                    $error("fresh: verdict with no request outstanding, actual %0b",
                           verdict_ch.fresh);
                    errors++;
                end
                else
                begin
                    want_fresh = verdict_due.pop_front();
                    if (verdict_ch.fresh !== want_fresh)
                    begin
                        $error("fresh: expected %0b, actual %0b", want_fresh,
                               verdict_ch.fresh);
                        errors++;
                    end
                end
            end
            if (pkt_ch.valid && pkt_ch.ready)
            begin
                req_taken = 1'b1;
                verdict_due.push_back(replay_verdict(pkt_ch.cmd, pkt_ch.seq_num));
            end
            if ((pkt_ch.valid && pkt_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        logic [63:0] s;
        logic        c;
        int unsigned pick;
        int unsigned span;

        pkt_ch.valid     = 1'b0;
        pkt_ch.cmd       = CMD_CHECK;
        pkt_ch.seq_num   = '0;
        verdict_ch.ready = 1'b0;
        rst_n            = 1'b0;
        win_high         = '0;
        win_map          = '0;
        gen_high         = '0;
        tx_calm          = 1'b0;
        rx_calm          = 1'b0;
        drv_busy         = 1'b0;
        req_taken        = 1'b0;
        verdict_took     = 1'b0;
        gap_cnt          = 0;
        stall_cnt        = 0;
        idle_cycles      = 0;
        errors           = 0;

        // Directed: replay, window edge, too old, long jump, wrapped distances
        queue_req(CMD_CHECK,  64'd0, 1'b0);
        queue_req(CMD_ACCEPT, 64'd0, 1'b0);
        queue_req(CMD_CHECK,  64'd0, 1'b0);
        queue_req(CMD_ACCEPT, 64'd5, 1'b0);
        queue_req(CMD_CHECK,  64'd0, 1'b0);
        queue_req(CMD_CHECK,  64'd3, 1'b0);
        queue_req(CMD_ACCEPT, 64'd3, 1'b0);
        queue_req(CMD_CHECK,  64'd3, 1'b0);
        queue_req(CMD_CHECK,  64'd6, 1'b0);
        queue_req(CMD_ACCEPT, 64'd1028, 1'b1);
        queue_req(CMD_CHECK,  64'd5, 1'b0);
        queue_req(CMD_CHECK,  64'd4, 1'b0);
        queue_req(CMD_ACCEPT, 64'd4, 1'b0);
        queue_req(CMD_ACCEPT, 64'd2052, 1'b0);
        queue_req(CMD_CHECK,  64'd1028, 1'b0);
        queue_req(CMD_CHECK,  64'd1029, 1'b0);
        queue_req(CMD_ACCEPT, 64'd2052 + 64'h8000_0000, 1'b0);
        queue_req(CMD_CHECK,  64'd2052 + 64'h8000_0000, 1'b0);
        queue_req(CMD_ACCEPT, 64'd2052 + 64'h1_0000_0000, 1'b0);
        queue_req(CMD_CHECK,  64'd2052 + 64'h1_0000_0000, 1'b0);
        queue_req(CMD_ACCEPT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        queue_req(CMD_CHECK,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        queue_req(CMD_ACCEPT, 64'hFFFF_FFFF_0000_0805, 1'b0);
        queue_req(CMD_CHECK,  64'h0000_0000_0000_0804, 1'b0);

        // Random: mostly traffic around the highest number, some far and wild
        for (int n = 0; n < RAND_REQS; n++)
        begin
            pick = $urandom_range(0, 99);
            span = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 1100);
            c    = $urandom_range(0, 1) ? CMD_ACCEPT : CMD_CHECK;
            if (pick < 40)
            begin
                c = CMD_CHECK;
                s = gen_high - span;
            end
            else if (pick < 65)
            begin
                c = CMD_ACCEPT;
                s = gen_high - span;
            end
            else if (pick < 82)
            begin
                c = CMD_ACCEPT;
                s = gen_high + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 1100)
                                                             : $urandom_range(1, 64));
            end
            else if (pick < 87)
            begin
                c = CMD_ACCEPT;
                s = gen_high + $urandom_range(1024, 32'h7FFF_FFFF);
            end
            else if (pick < 93)
            begin
                s = {$urandom, $urandom};
            end
            else if (pick < 97)
            begin
                // same low half, random upper half: aliases onto the window
                s = (gen_high ^ {$urandom, 32'h0}) - span;
            end
            else
            begin
                s = $urandom_range(0, 1) ? gen_high + 64'h8000_0000
                                         : gen_high - 64'h8000_0000 + span;
            end
            queue_req(c, s, (n % 150) == 75);
        end

        // Hold reset, then release on a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: all requests taken and every verdict back
        while (pend_q.size() != 0 || drv_busy || verdict_due.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
